// ===== sv/hcb_pkg.sv =====
package hcb_pkg;

  // Field widths of the ports
  localparam int PITCH_W    = 13;
  localparam int POS_W      = 18;
  localparam int ENERGY_W   = 16;
  localparam int COUNT_W    = 6;
  localparam int IDX_W      = 5;
  localparam int TOTAL_W    = 20;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Search window is four pitches; squared offsets fit in twice the window width
  localparam int WIN_W = PITCH_W + 2;
  localparam int SQ_W  = 2 * WIN_W;

  // Clamped cell counts go up to GRID_ROWS or GRID_COLS (32 by default)
  localparam int LIM_W = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Register values after reset
  localparam logic [PITCH_W-1:0]         RST_PITCH_X  = 13'd1151;
  localparam logic [PITCH_W-1:0]         RST_SHIFT_X  = 13'd576;
  localparam logic [PITCH_W-1:0]         RST_PITCH_Y  = 13'd997;
  localparam logic signed [POS_W-1:0]    RST_ORIGIN_X = -18'sd10360;
  localparam logic [ENERGY_W-1:0]        RST_ENERGY   = 16'd100;
  localparam logic [COUNT_W-1:0]         RST_ROWS     = 6'd31;
  localparam logic [COUNT_W-1:0]         RST_COLS     = 6'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_PITCH_X  = 3'd0,
    REG_ROW_SHIFT_X   = 3'd1,
    REG_ROW_PITCH_Y   = 3'd2,
    REG_GRID_ORIGIN_X = 3'd3,
    REG_HIT_ENERGY    = 3'd4,
    REG_ROWS_USED     = 3'd5,
    REG_COLS_USED     = 3'd6
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED = 2'd0,
    ST_MISS   = 2'd1,
    ST_READ   = 2'd2
  } status_t;

  typedef enum logic {
    OP_DEPOSIT = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_DRAIN,
    S_RD,
    S_RESULT
  } state_t;

  // Flags that travel with each distance result
  typedef struct packed {
    logic valid;
    logic in_win;
  } dist_flags_t;

endpackage

// ===== sv/hcb_ram.sv =====
module hcb_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/hcb_dist.sv =====
module hcb_dist #(
  parameter int CX_W  = 22,
  parameter int TAG_W = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               issue,
  input  logic signed [CX_W-1:0]             cx,
  input  logic signed [CX_W-1:0]             cy,
  input  logic signed [hcb_pkg::POS_W-1:0]   hx,
  input  logic signed [hcb_pkg::POS_W-1:0]   hy,
  input  logic [hcb_pkg::WIN_W-1:0]          win,
  input  logic [TAG_W-1:0]                   tag_in,
  output hcb_pkg::dist_flags_t               flags,
  output logic [hcb_pkg::SQ_W-1:0]           sq_x,
  output logic [hcb_pkg::SQ_W-1:0]           sq_y,
  output logic [TAG_W-1:0]                   tag_out,
  output logic                               busy
);
  import hcb_pkg::*;

  localparam int DIFF_W = CX_W + 1;

  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic [DIFF_W-1:0]        adx, ady;
  logic                     in_win;

  logic               a_valid_r, a_win_r;
  logic [WIN_W-1:0]   dx_r, dy_r;
  logic [TAG_W-1:0]   a_tag_r;
  logic               b_valid_r, b_win_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic [TAG_W-1:0]   b_tag_r;

  // Absolute offsets and window test
  always_comb begin
    diff_x = DIFF_W'(cx) - DIFF_W'(hx);
    diff_y = DIFF_W'(cy) - DIFF_W'(hy);
    adx    = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    ady    = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    in_win = (adx <= DIFF_W'(win)) && (ady <= DIFF_W'(win));
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= issue;
      b_valid_r <= a_valid_r;
    end
  end

  // Offset stage, then square stage
  always_ff @(posedge clk) begin
    a_win_r <= in_win;
    dx_r    <= adx[WIN_W-1:0];
    dy_r    <= ady[WIN_W-1:0];
    a_tag_r <= tag_in;
    b_win_r <= a_win_r;
    sqx_r   <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r   <= SQ_W'(dy_r) * SQ_W'(dy_r);
    b_tag_r <= a_tag_r;
  end

  assign flags.valid  = b_valid_r;
  assign flags.in_win = b_win_r;
  assign sq_x         = sqx_r;
  assign sq_y         = sqy_r;
  assign tag_out      = b_tag_r;
  assign busy         = a_valid_r | b_valid_r;

endmodule

// ===== sv/hex_cell_energy_binner.sv =====
// Deposit: a search over the clamped rows_used*cols_used cells (one cell distance per cycle),
//   then drain, read and update the cell; a miss skips the read, no cell in use the search too.
// Read and clear: the cell is read, then the result is registered and the cell cleared; an
// out-of-range cell is not read. One item is in work at a time; a stalled result holds the input.
// Reset (synchronous, active low) restores the registers and then clears the energy
//   store, all GRID_ROWS*GRID_COLS entries (1024 by default), with in_ready low.
module hex_cell_energy_binner #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [hcb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hcb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic signed [hcb_pkg::POS_W-1:0]      in_hit_x,
  input  logic signed [hcb_pkg::POS_W-1:0]      in_hit_y,
  input  logic [hcb_pkg::IDX_W-1:0]             in_read_row,
  input  logic [hcb_pkg::IDX_W-1:0]             in_read_col,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hcb_pkg::STATUS_W-1:0]          out_status,
  output logic [hcb_pkg::IDX_W-1:0]             out_cell_row,
  output logic [hcb_pkg::IDX_W-1:0]             out_cell_col,
  output logic [hcb_pkg::TOTAL_W-1:0]           out_cell_total
);
  import hcb_pkg::*;

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TAG_W  = ROW_W + COL_W + ADDR_W;
  localparam int CX_W   = $clog2(2**(POS_W-1) + (GRID_ROWS + GRID_COLS) * (2**PITCH_W - 1)
                                 + 1) + 1;
  localparam int D2_W   = SQ_W + 1;
  localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(GRID_ROWS);
  localparam logic [LIM_W-1:0] COLS_LIM = LIM_W'(GRID_COLS);

  // Configuration registers
  logic [PITCH_W-1:0]      pitch_x_r, shift_x_r, pitch_y_r;
  logic signed [POS_W-1:0] origin_x_r;
  logic [ENERGY_W-1:0]     energy_r;
  logic [COUNT_W-1:0]      rows_used_r, cols_used_r;

  // Sequencer and datapath
  state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]       clr_r;
  logic [ROW_W-1:0]        r_cnt_r;
  logic [COL_W-1:0]        c_cnt_r;
  logic [ADDR_W-1:0]       addr_r, row_addr_r, row_addr_nxt;
  logic signed [CX_W-1:0]  row_x_r, row_x_nxt, cx_r, cy_r;
  logic signed [CX_W-1:0]  pitch_x_ext, shift_x_ext, pitch_y_ext;
  logic signed [POS_W-1:0] hx_r, hy_r;
  op_t                     op_r;
  logic                    tgt_ok_r;
  logic [ADDR_W-1:0]       tgt_addr_r;
  logic [IDX_W-1:0]        res_row_r, res_col_r;
  logic                    found_r;
  logic [D2_W-1:0]         best_r, d2;
  logic [TAG_W-1:0]        best_tag_r;
  logic [LIM_W-1:0]        nr_lim, nc_lim;
  logic                    col_last, row_last, empty_grid;
  logic                    in_acc, out_free, read_in_range;

  // Distance unit
  dist_flags_t             dflags;
  logic [SQ_W-1:0]         sq_x, sq_y;
  logic [TAG_W-1:0]        dtag;
  logic                    dbusy;

  // Store
  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [TOTAL_W-1:0]      ram_wdata, ram_rdata;
  logic [TOTAL_W:0]        sum;
  logic [TOTAL_W-1:0]      sat;

  // Result register
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic [TOTAL_W-1:0]      out_total_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_x_r   <= RST_PITCH_X;
      shift_x_r   <= RST_SHIFT_X;
      pitch_y_r   <= RST_PITCH_Y;
      origin_x_r  <= RST_ORIGIN_X;
      energy_r    <= RST_ENERGY;
      rows_used_r <= RST_ROWS;
      cols_used_r <= RST_COLS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_PITCH_X:  pitch_x_r   <= cfg_data[PITCH_W-1:0];
        REG_ROW_SHIFT_X:   shift_x_r   <= cfg_data[PITCH_W-1:0];
        REG_ROW_PITCH_Y:   pitch_y_r   <= cfg_data[PITCH_W-1:0];
        REG_GRID_ORIGIN_X: origin_x_r  <= $signed(cfg_data[POS_W-1:0]);
        REG_HIT_ENERGY:    energy_r    <= cfg_data[ENERGY_W-1:0];
        REG_ROWS_USED:     rows_used_r <= cfg_data[COUNT_W-1:0];
        REG_COLS_USED:     cols_used_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts, detect scan ends, extend steps
  always_comb begin
    nr_lim      = (LIM_W'(rows_used_r) > ROWS_LIM) ? ROWS_LIM : LIM_W'(rows_used_r);
    nc_lim      = (LIM_W'(cols_used_r) > COLS_LIM) ? COLS_LIM : LIM_W'(cols_used_r);
    empty_grid  = (nr_lim == '0) || (nc_lim == '0);
    col_last    = (LIM_W'(c_cnt_r) + LIM_W'(1)) == nc_lim;
    row_last    = (LIM_W'(r_cnt_r) + LIM_W'(1)) == nr_lim;
    pitch_x_ext = CX_W'($signed({1'b0, pitch_x_r}));
    shift_x_ext = CX_W'($signed({1'b0, shift_x_r}));
    pitch_y_ext = CX_W'($signed({1'b0, pitch_y_r}));
    row_x_nxt    = row_x_r + pitch_x_ext;
    row_addr_nxt = row_addr_r + ADDR_W'(GRID_COLS);
    read_in_range = (LIM_W'(in_read_row) < ROWS_LIM) && (LIM_W'(in_read_col) < COLS_LIM);
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Shared distance unit, one cell per cycle
  hcb_dist #(
    .CX_W  (CX_W),
    .TAG_W (TAG_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (state_r == S_SEARCH),
    .cx      (cx_r),
    .cy      (cy_r),
    .hx      (hx_r),
    .hy      (hy_r),
    .win     ({pitch_x_r, 2'b00}),
    .tag_in  ({r_cnt_r, c_cnt_r, addr_r}),
    .flags   (dflags),
    .sq_x    (sq_x),
    .sq_y    (sq_y),
    .tag_out (dtag),
    .busy    (dbusy)
  );

  assign d2 = D2_W'(sq_x) + D2_W'(sq_y);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (op_t'(in_op) == OP_READ) begin
            state_nxt = read_in_range ? S_RD : S_RESULT;
          end else begin
            state_nxt = empty_grid ? S_DRAIN : S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (col_last && row_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!dbusy) state_nxt = found_r ? S_RD : S_RESULT;
      end
      S_RD:     state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n)                   clr_r <= '0;
    else if (state_r == S_CLEAR)  clr_r <= clr_r + ADDR_W'(1);
  end

  // Scan counters and centre coordinates
  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_cnt_r    <= '0;
      c_cnt_r    <= '0;
      addr_r     <= '0;
      row_addr_r <= '0;
      row_x_r    <= CX_W'(origin_x_r);
      cx_r       <= CX_W'(origin_x_r);
      cy_r       <= '0;
      hx_r       <= in_hit_x;
      hy_r       <= in_hit_y;
    end else if (state_r == S_SEARCH) begin
      if (col_last) begin
        c_cnt_r    <= '0;
        r_cnt_r    <= r_cnt_r + ROW_W'(1);
        row_x_r    <= row_x_nxt;
        cx_r       <= row_x_nxt;
        cy_r       <= '0;
        row_addr_r <= row_addr_nxt;
        addr_r     <= row_addr_nxt;
      end else begin
        c_cnt_r <= c_cnt_r + COL_W'(1);
        cx_r    <= cx_r + shift_x_ext;
        cy_r    <= cy_r + pitch_y_ext;
        addr_r  <= addr_r + ADDR_W'(1);
      end
    end
  end

  // Keep the nearest centre; a tie keeps the earlier cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_acc) begin
      found_r <= 1'b0;
    end else if (dflags.valid && dflags.in_win && (!found_r || d2 < best_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dflags.valid && dflags.in_win && (!found_r || d2 < best_r)) begin
      best_r     <= d2;
      best_tag_r <= dtag;
    end
  end

  // Target cell of the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= op_t'(in_op);
      tgt_ok_r   <= (op_t'(in_op) == OP_READ) && read_in_range;
      tgt_addr_r <= ADDR_W'(in_read_row * GRID_COLS + in_read_col);
      res_row_r  <= in_read_row;
      res_col_r  <= in_read_col;
    end else if (state_r == S_DRAIN && !dbusy) begin
      tgt_ok_r   <= found_r;
      tgt_addr_r <= best_tag_r[ADDR_W-1:0];
      res_row_r  <= IDX_W'(best_tag_r[TAG_W-1 -: ROW_W]);
      res_col_r  <= IDX_W'(best_tag_r[ADDR_W+COL_W-1 -: COL_W]);
    end
  end

  // Saturating add of the hit energy
  always_comb begin
    sum = (TOTAL_W+1)'(ram_rdata) + (TOTAL_W+1)'(energy_r);
    sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  // Store port control
  always_comb begin
    ram_re    = (state_r == S_RD);
    ram_we    = (state_r == S_CLEAR) || (state_r == S_RESULT && out_free && tgt_ok_r);
    ram_waddr = (state_r == S_CLEAR) ? clr_r : tgt_addr_r;
    ram_wdata = (state_r == S_CLEAR || op_r == OP_READ) ? '0 : sat;
  end

  hcb_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tgt_addr_r),
    .rdata (ram_rdata)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESULT && out_free) begin
      if (op_r == OP_READ) begin
        out_status_r <= ST_READ;
        out_row_r    <= res_row_r;
        out_col_r    <= res_col_r;
        out_total_r  <= tgt_ok_r ? ram_rdata : '0;
      end else if (tgt_ok_r) begin
        out_status_r <= ST_PLACED;
        out_row_r    <= res_row_r;
        out_col_r    <= res_col_r;
        out_total_r  <= sat;
      end else begin
        out_status_r <= ST_MISS;
        out_row_r    <= '0;
        out_col_r    <= '0;
        out_total_r  <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cell_row   = out_row_r;
  assign out_cell_col   = out_col_r;
  assign out_cell_total = out_total_r;

  // The store is left alone while the scan runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> !ram_we)
    else $error("store written during search");

  // A new result only comes out of the result state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result appeared outside result state");

  // The best distance never grows within one search
  assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && $past(found_r)) |-> (best_r <= $past(best_r)))
    else $error("best distance increased");

  // A missed hit reports an empty cell
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_MISS) |-> (out_total_r == '0 && out_row_r == '0))
    else $error("miss result carries data");

endmodule
